// ===== hdl/swra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swra_pkg: shared types and constants of the window resampler
// Kernel codes, register indexes, band lanes, the beat tag passed from the
// front to the back end, the coefficient function and the lane placement.
// ----------------------------------------------------------------------------
package swra_pkg;

   // Default sizing
   localparam int MAX_TAPS_DEFAULT   = 9;
   localparam int COEF_FRAC_DEFAULT  = 16;
   localparam int QUEUE_DEPTH        = 4;

   // Kernel codes (code three behaves as nearest)
   localparam logic [1:0] KERNEL_NEAREST  = 2'd0;
   localparam logic [1:0] KERNEL_BILINEAR = 2'd1;
   localparam logic [1:0] KERNEL_LANCZOS  = 2'd2;

   localparam logic [3:0] NEAREST_TAPS  = 4'd1;
   localparam logic [3:0] BILINEAR_TAPS = 4'd3;
   localparam logic [3:0] LANCZOS_TAPS  = 4'd9;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_KERNEL_MODE   = 2'd0,
      CSR_BAND_COUNT    = 2'd1,
      CSR_NODATA_ENABLE = 2'd2,
      CSR_NODATA_VALUE  = 2'd3
   } swra_csr_type;

   // Band lanes in arrival order
   typedef enum logic [1:0] {
      LANE_RED   = 2'd0,
      LANE_GREEN = 2'd1,
      LANE_BLUE  = 2'd2,
      LANE_ALPHA = 2'd3
   } swra_lane_type;

   localparam logic [2:0] MAX_BANDS    = 3'd4;
   localparam logic [7:0] PIXEL_MAX    = 8'd255;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Lanczos ROM by distance from center, Q0.24
   localparam int ROM_FRAC   = 24;
   localparam int COEF_MAX_W = ROM_FRAC + 1;
   localparam logic [23:0] LANCZOS_ROM [5] = '{
      24'd5563492, 24'd4142328, 24'd1464534, 24'd0, 24'd0
   };
   localparam logic [3:0] ROM_SPAN = 4'd5;

   // Classification of one beat, produced by the front end
   typedef struct packed {
      logic          skip;
      logic          nodata;
      logic          win_end;
      logic          pix_end;
      swra_lane_type lane;
      logic          alpha_fill;
   } swra_tag_type;

   // Kernel weight for a tap at a distance from the window center
   function automatic logic [COEF_MAX_W-1:0] coef_value(
      input logic [1:0] mode,
      input logic [3:0] offset,
      input int         frac
   );
      logic [COEF_MAX_W-1:0] v;
      v = '0;
      if (mode == KERNEL_BILINEAR) begin
         v = (offset == 4'd0) ? (COEF_MAX_W'(1) << (frac - 1))
                              : (COEF_MAX_W'(1) << (frac - 2));
      end else if (mode == KERNEL_LANCZOS) begin
         v = (offset < ROM_SPAN) ? COEF_MAX_W'(LANCZOS_ROM[offset[2:0]]) : '0;
         if (frac < ROM_FRAC) begin
            v = (v + (COEF_MAX_W'(1) << (ROM_FRAC - 1 - frac))) >> (ROM_FRAC - frac);
         end
      end else begin
         v = COEF_MAX_W'(1) << frac;
      end
      return v;
   endfunction

   // Place a clamped band value into its lane of the packed pixel
   function automatic logic [31:0] lane_place(
      input swra_lane_type lane,
      input logic [7:0]    val
   );
      logic [31:0] w;
      w = '0;
      case (lane)
         LANE_RED:   w[23:16] = val;
         LANE_GREEN: w[15:8]  = val;
         LANE_BLUE:  w[7:0]   = val;
         default:    w[31:24] = val;
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/swra_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swra_front: beat intake and classification
// Holds the configuration registers, tracks the sample index and band of each
// beat, looks up the two kernel coefficients and forms their product weight.
// ----------------------------------------------------------------------------
module swra_front #(
   parameter int MAX_TAPS       = swra_pkg::MAX_TAPS_DEFAULT,
   parameter int COEF_FRAC_BITS = swra_pkg::COEF_FRAC_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // sample
   input  logic                        req_tuser,   // req_type
   input  logic                        csr_we,
   input  logic [1:0]                  csr_addr,
   input  logic [7:0]                  csr_wdata,
   output logic                        push_valid,
   input  logic                        push_ready,
   output swra_pkg::swra_tag_type      push_tag,
   output logic [7:0]                  push_sample,
   output logic [2*COEF_FRAC_BITS:0]   push_weight
);
   import swra_pkg::*;

   localparam int CW    = COEF_FRAC_BITS + 1;
   localparam int WGT_W = 2 * COEF_FRAC_BITS + 1;
   localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS * MAX_TAPS) : 1;
   localparam int TN    = int'(NEAREST_TAPS);
   localparam int TB    = (int'(BILINEAR_TAPS) > MAX_TAPS) ? MAX_TAPS : int'(BILINEAR_TAPS);
   localparam int TL    = (int'(LANCZOS_TAPS) > MAX_TAPS) ? MAX_TAPS : int'(LANCZOS_TAPS);

   logic [1:0]       mode_ff, mode_in;
   logic [2:0]       bands_cfg_ff, bands_cfg_in;
   logic             nd_en_ff, nd_en_in;
   logic [7:0]       nd_val_ff, nd_val_in;

   // Linear sample index, and its row and column split for each window size
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] bl_row_ff, bl_row_in;
   logic [IDX_W-1:0] bl_col_ff, bl_col_in;
   logic [IDX_W-1:0] lz_row_ff, lz_row_in;
   logic [IDX_W-1:0] lz_col_ff, lz_col_in;
   logic [1:0]       band_ff, band_in;

   logic [IDX_W-1:0] last_idx;
   logic [IDX_W-1:0] half_idx;
   logic [IDX_W-1:0] ctr;
   logic [IDX_W-1:0] row;
   logic [IDX_W-1:0] col;
   logic [IDX_W-1:0] row_dist;
   logic [IDX_W-1:0] col_dist;
   logic [2:0]       bands;
   logic             in_win;
   logic             win_end;
   logic             pix_end;
   logic             at_center;
   logic [CW-1:0]    coef_row;
   logic [CW-1:0]    coef_col;
   logic             accept;

   // Write configuration registers
   always_comb begin
      mode_in      = mode_ff;
      bands_cfg_in = bands_cfg_ff;
      nd_en_in     = nd_en_ff;
      nd_val_in    = nd_val_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_KERNEL_MODE:   mode_in      = csr_wdata[1:0];
            CSR_BAND_COUNT:    bands_cfg_in = csr_wdata[2:0];
            CSR_NODATA_ENABLE: nd_en_in     = csr_wdata[0];
            CSR_NODATA_VALUE:  nd_val_in    = csr_wdata;
         endcase
      end
   end

   // Window geometry of the active kernel, capped
   always_comb begin
      if (mode_ff == KERNEL_BILINEAR) begin
         last_idx = IDX_W'(TB * TB - 1);
         half_idx = IDX_W'(TB * TB / 2);
         ctr      = IDX_W'(TB / 2);
         row      = bl_row_ff;
         col      = bl_col_ff;
      end else if (mode_ff == KERNEL_LANCZOS) begin
         last_idx = IDX_W'(TL * TL - 1);
         half_idx = IDX_W'(TL * TL / 2);
         ctr      = IDX_W'(TL / 2);
         row      = lz_row_ff;
         col      = lz_col_ff;
      end else begin
         last_idx = IDX_W'(TN * TN - 1);
         half_idx = IDX_W'(TN * TN / 2);
         ctr      = IDX_W'(TN / 2);
         row      = idx_ff;
         col      = '0;
      end
   end

   // Band count clamped to one..four
   always_comb begin
      if (bands_cfg_ff == 3'd0) begin
         bands = 3'd1;
      end else if (bands_cfg_ff > MAX_BANDS) begin
         bands = MAX_BANDS;
      end else begin
         bands = bands_cfg_ff;
      end
   end

   // Classify the beat; a beat past the window weighs zero and closes it
   always_comb begin
      in_win    = (idx_ff <= last_idx);
      win_end   = (idx_ff >= last_idx);
      pix_end   = win_end && (({1'b0, band_ff} + 3'd1) >= bands);
      at_center = (idx_ff == half_idx);
      row_dist  = (row > ctr) ? (row - ctr) : (ctr - row);
      col_dist  = (col > ctr) ? (col - ctr) : (ctr - col);
      coef_row  = CW'(coef_value(mode_ff, 4'(row_dist), COEF_FRAC_BITS));
      coef_col  = CW'(coef_value(mode_ff, 4'(col_dist), COEF_FRAC_BITS));

      push_tag.skip       = req_tuser;
      push_tag.nodata     = at_center && nd_en_ff && (req_tdata == nd_val_ff);
      push_tag.win_end    = win_end;
      push_tag.pix_end    = pix_end;
      push_tag.lane       = swra_lane_type'(band_ff);
      push_tag.alpha_fill = (bands < MAX_BANDS);
      push_sample         = req_tdata;
      push_weight         = in_win ? WGT_W'(coef_row * coef_col) : '0;
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;

   // Advance window position
   always_comb begin
      idx_in    = idx_ff;
      bl_row_in = bl_row_ff;
      bl_col_in = bl_col_ff;
      lz_row_in = lz_row_ff;
      lz_col_in = lz_col_ff;
      band_in   = band_ff;
      if (accept) begin
         if (req_tuser) begin
            idx_in    = '0;
            bl_row_in = '0;
            bl_col_in = '0;
            lz_row_in = '0;
            lz_col_in = '0;
            band_in   = '0;
         end else if (win_end) begin
            idx_in    = '0;
            bl_row_in = '0;
            bl_col_in = '0;
            lz_row_in = '0;
            lz_col_in = '0;
            band_in   = pix_end ? 2'd0 : (band_ff + 2'd1);
         end else begin
            idx_in = idx_ff + IDX_W'(1);
            if (bl_col_ff == IDX_W'(TB - 1)) begin
               bl_col_in = '0;
               bl_row_in = bl_row_ff + IDX_W'(1);
            end else begin
               bl_col_in = bl_col_ff + IDX_W'(1);
            end
            if (lz_col_ff == IDX_W'(TL - 1)) begin
               lz_col_in = '0;
               lz_row_in = lz_row_ff + IDX_W'(1);
            end else begin
               lz_col_in = lz_col_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= KERNEL_NEAREST;
         bands_cfg_ff <= 3'd3;
         nd_en_ff     <= 1'b0;
         nd_val_ff    <= 8'd0;
         idx_ff       <= '0;
         bl_row_ff    <= '0;
         bl_col_ff    <= '0;
         lz_row_ff    <= '0;
         lz_col_ff    <= '0;
         band_ff      <= '0;
      end else begin
         mode_ff      <= mode_in;
         bands_cfg_ff <= bands_cfg_in;
         nd_en_ff     <= nd_en_in;
         nd_val_ff    <= nd_val_in;
         idx_ff       <= idx_in;
         bl_row_ff    <= bl_row_in;
         bl_col_ff    <= bl_col_in;
         lz_row_ff    <= lz_row_in;
         lz_col_ff    <= lz_col_in;
         band_ff      <= band_in;
      end
   end

endmodule

// ===== hdl/swra_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swra_queue: short beat queue between front and back end
// Register FIFO with occupancy count; lets either side stall alone.
// ----------------------------------------------------------------------------
module swra_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = swra_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   import swra_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Move pointers with wrap at depth
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : (wr_ff + PTR_W'(1));
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : (rd_ff + PTR_W'(1));
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hdl/swra_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swra_back: weighting, accumulation and pixel assembly
// Stage one multiplies sample by weight; stage two accumulates, closes
// windows into band lanes and loads the result register.
// ----------------------------------------------------------------------------
module swra_back #(
   parameter int COEF_FRAC_BITS = swra_pkg::COEF_FRAC_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  swra_pkg::swra_tag_type      pop_tag,
   input  logic [7:0]                  pop_sample,
   input  logic [2*COEF_FRAC_BITS:0]   pop_weight,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,   // pixel_argb
   output logic                        rsp_tuser    // pixel_blank
);
   import swra_pkg::*;

   localparam int FRAC2     = 2 * COEF_FRAC_BITS;
   localparam int ACC_W     = FRAC2 + 9;
   localparam int SUM_INT_W = ACC_W - FRAC2;

   logic               adv;

   logic               s1_valid_ff, s1_valid_in;
   swra_tag_type       s1_tag_ff;
   logic [ACC_W-1:0]   s1_prod_ff;

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [31:0]        word_ff, word_in;
   logic               hit_ff, hit_in;

   logic               out_valid_ff, out_valid_in;
   logic [31:0]        out_data_ff, out_data_in;
   logic               out_blank_ff, out_blank_in;

   logic [ACC_W-1:0]   acc_sum;
   logic [SUM_INT_W-1:0] band_int;
   logic [7:0]         band_val;
   logic [31:0]        word_next;
   logic               hit_next;

   // Move the pipeline whenever the result register can take a beat
   assign adv         = !out_valid_ff || rsp_tready;
   assign pop_ready   = adv;
   assign s1_valid_in = adv ? pop_valid : s1_valid_ff;

   // Stage one: weight the sample
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff  <= pop_tag;
         s1_prod_ff <= ACC_W'(pop_sample * pop_weight);
      end
   end

   // Stage two: accumulate, close the window, emit the pixel
   always_comb begin
      acc_sum   = acc_ff + s1_prod_ff;
      band_int  = acc_sum[ACC_W-1:FRAC2];
      band_val  = (band_int > SUM_INT_W'(PIXEL_MAX)) ? PIXEL_MAX : band_int[7:0];
      word_next = word_ff | lane_place(s1_tag_ff.lane, band_val);
      hit_next  = hit_ff | s1_tag_ff.nodata;

      acc_in       = acc_ff;
      word_in      = word_ff;
      hit_in       = hit_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_blank_in = out_blank_ff;

      if (adv && s1_valid_ff) begin
         if (s1_tag_ff.skip) begin
            // Drop the partial pixel and emit a blank one
            acc_in       = '0;
            word_in      = '0;
            hit_in       = 1'b0;
            out_valid_in = 1'b1;
            out_data_in  = '0;
            out_blank_in = 1'b1;
         end else if (s1_tag_ff.pix_end) begin
            acc_in       = '0;
            word_in      = '0;
            hit_in       = 1'b0;
            out_valid_in = 1'b1;
            out_blank_in = hit_next;
            if (hit_next) begin
               out_data_in = '0;
            end else if (s1_tag_ff.alpha_fill) begin
               out_data_in = word_next | {ALPHA_OPAQUE, 24'd0};
            end else begin
               out_data_in = word_next;
            end
         end else if (s1_tag_ff.win_end) begin
            acc_in  = '0;
            word_in = word_next;
            hit_in  = hit_next;
         end else begin
            acc_in = acc_sum;
            hit_in = hit_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      out_blank_ff <= out_blank_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         word_ff      <= '0;
         hit_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         word_ff      <= word_in;
         hit_ff       <= hit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_blank_ff;

endmodule

// ===== hdl/separable_window_resample_argb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_window_resample_argb_core: windowed ARGB resampler
// Weights each band's window by a separable kernel, clamps each band sum to
// a byte and packs the bands into one ARGB pixel.
// ----------------------------------------------------------------------------
// Throughput: one window beat per cycle while the result channel is not
//   stalled; a pixel takes band_count windows of 1, 9 or 81 beats. The back
//   end's multiply-accumulate sets that pace. A pixel leaves after its last
//   beat or skip beat through queue write, weighting stage, result register.
// Reset: synchronous; clears the queue, the window counters, the accumulator
//   and the registers to nearest kernel, three bands, nodata off.
module separable_window_resample_argb_core #(
   parameter int MAX_TAPS       = swra_pkg::MAX_TAPS_DEFAULT,
   parameter int COEF_FRAC_BITS = swra_pkg::COEF_FRAC_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] sample
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] pixel_argb
   output logic        rsp_tuser,   // [0] pixel_blank
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);
   import swra_pkg::*;

   localparam int WGT_W  = 2 * COEF_FRAC_BITS + 1;
   localparam int TAG_W  = $bits(swra_tag_type);
   localparam int DATA_W = WGT_W + 8 + TAG_W;

   logic               push_valid;
   logic               push_ready;
   swra_tag_type       push_tag;
   logic [7:0]         push_sample;
   logic [WGT_W-1:0]   push_weight;
   logic [DATA_W-1:0]  push_data;

   logic               pop_valid;
   logic               pop_ready;
   logic [DATA_W-1:0]  pop_data;
   swra_tag_type       pop_tag;
   logic [7:0]         pop_sample;
   logic [WGT_W-1:0]   pop_weight;

   swra_front #(
      .MAX_TAPS       (MAX_TAPS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_tag    (push_tag),
      .push_sample (push_sample),
      .push_weight (push_weight)
   );

   // Pack beats for the queue
   assign push_data = {push_weight, push_sample, push_tag};

   swra_queue #(
      .DATA_W (DATA_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_weight, pop_sample, pop_tag} = pop_data;

   swra_back #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_tag    (pop_tag),
      .pop_sample (pop_sample),
      .pop_weight (pop_weight),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== hdl/swra_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swra_check: port checks for the window resampler
// Watches the result channel over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module swra_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // Blank pixels are fully transparent zero
   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("blank pixel carries nonzero data");

   // Reset leaves no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind separable_window_resample_argb_core swra_check u_swra_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
